// ===== hw/rtl/bmhc_pkg.sv =====
// shared types and constants for the byte move-halfway cache
// no dependencies

package bmhc_pkg;

  // miss inserts land at this position once the list holds enough entries
  localparam int unsigned INSERT_LIMIT = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE
  } state_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic search;  // capture first-match flag
    logic load;    // take the request byte
    logic shift;   // take the left neighbor's entry
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/bmhc_cell.sv =====
// one list cell: holds an entry, joins the first-match chain, shifts right
// depends on bmhc_pkg

module bmhc_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            value,
  input  logic [7:0]            left_entry,
  input  logic                  occupied,
  input  logic                  found_in,
  input  bmhc_pkg::cell_ctrl_t  ctrl,
  output logic [7:0]            entry,
  output logic                  found_out,
  output logic                  first
);
  import bmhc_pkg::*;

  logic match;

  assign match     = occupied && (entry == value);
  assign found_out = found_in || match;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      entry <= value;
    end else if (ctrl.shift) begin
      entry <= left_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first <= 1'b0;
    end else if (ctrl.search) begin
      first <= match && !found_in;
    end
  end

endmodule

// ===== hw/rtl/byte_move_halfway_cache_top.sv =====
// top level of the byte move-halfway cache: sequencer and a row of list cells
// depends on bmhc_pkg and bmhc_cell
//
//   channel   signals                           direction
//   request   req_valid, req_stall, value       into the block
//   result    res_valid, res_stall, hit,        out of the block
//             match_position
//
// each request is handled in order: accept, search along the cell chain, update
// the list and load the result register; the next request is accepted in the
// cycle after the update. the first-match chain through all CAPACITY cells
// sets the search cycle. rst is synchronous and empties the list at once.
// a waiting result holds the block in its update cycle until it is taken;
// a new request may be taken while the last result waits.

module byte_move_halfway_cache_top #(
  parameter int unsigned CAPACITY = 7
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [7:0] value,
  output logic       res_valid,
  input  logic       res_stall,
  output logic       hit,
  output logic [2:0] match_position
);
  import bmhc_pkg::*;

  localparam int unsigned PW = $clog2(CAPACITY);
  localparam int unsigned FW = $clog2(CAPACITY + 1);

  state_t state;
  state_t state_next;

  logic [7:0]    req_byte;
  logic [FW-1:0] fill_count;

  // cell row signals
  logic [7:0]       entry   [CAPACITY];
  logic [CAPACITY:0] found;
  logic [CAPACITY-1:0] first;
  cell_ctrl_t       ctrl    [CAPACITY];

  logic          accept;
  logic          res_free;
  logic          do_update;
  logic          found_any;
  logic [PW-1:0] pos;
  logic [PW-1:0] target;
  logic [PW-1:0] upper;
  logic [PW-1:0] ins;
  logic          full;

  assign accept    = req_valid && !req_stall;
  assign res_free  = !res_valid || !res_stall;
  assign do_update = (state == ST_UPDATE) && res_free;
  assign found[0]  = 1'b0;
  assign full      = (fill_count == FW'(CAPACITY));

  // flags are one-hot after search, so an or of indexes gives the position
  always_comb begin
    found_any = |first;
    pos       = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) begin
        pos = pos | PW'(i);
      end
    end
  end

  // hit: move to half the position; miss: insert at min(2, fill)
  always_comb begin
    if (fill_count <= FW'(INSERT_LIMIT)) begin
      ins = PW'(fill_count);
    end else begin
      ins = PW'(INSERT_LIMIT);
    end
    if (found_any) begin
      target = pos >> 1;
      upper  = pos;
    end else begin
      target = ins;
      upper  = full ? PW'(CAPACITY - 1) : PW'(fill_count);
    end
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [7:0] left;
      if (g == 0) begin : g_head
        assign left = req_byte;
      end else begin : g_body
        assign left = entry[g-1];
      end

      always_comb begin
        ctrl[g].search = (state == ST_SEARCH);
        ctrl[g].load   = do_update && (PW'(g) == target);
        ctrl[g].shift  = do_update && (PW'(g) > target) && (PW'(g) <= upper);
      end

      bmhc_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .value      (req_byte),
        .left_entry (left),
        .occupied   (FW'(g) < fill_count),
        .found_in   (found[g]),
        .ctrl       (ctrl[g]),
        .entry      (entry[g]),
        .found_out  (found[g+1]),
        .first      (first[g])
      );
    end
  endgenerate

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // request byte capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_byte <= value;
    end
  end

  // fill count grows on a miss until the list is full
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (do_update && !found_any && !full) begin
      fill_count <= fill_count + FW'(1);
    end
  end

  // result register, parts the list from the result side
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (do_update) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_update) begin
      hit            <= found_any;
      match_position <= found_any ? 3'(pos) : 3'd0;
    end
  end

endmodule
